// ===== sv/gpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_pkg
// Types, codes and constants shared by the pace tracker files.
// ----------------------------------------------------------------------------
package gpt_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int COS_ENTRIES    = 91;

  // op codes
  localparam logic [2:0] OP_FIX    = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // fix results
  localparam logic [1:0] FIX_REJECT = 2'd0;
  localparam logic [1:0] FIX_BASE   = 2'd1;
  localparam logic [1:0] FIX_COMMIT = 2'd2;
  localparam logic [1:0] FIX_NONE   = 2'd3;

  // run modes
  localparam logic [1:0] MODE_WAIT  = 2'd0;
  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_PAUSE = 2'd3;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;
  localparam logic [CFG_IW-1:0] CFG_MIN_STEP = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MAX_INT  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MAX_SPD  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WINDOW   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_STALE    = 3'd4;

  localparam logic [19:0] RST_MIN_STEP = 20'd20000;
  localparam logic [19:0] RST_MAX_INT  = 20'd120000;
  localparam logic [7:0]  RST_MAX_SPD  = 8'd15;
  localparam logic [23:0] RST_WINDOW   = 24'd200000;
  localparam logic [15:0] RST_STALE    = 16'd10;

  localparam logic signed [31:0] LAT_LIMIT = 32'sd90000000;
  localparam logic signed [31:0] LON_LIMIT = 32'sd180000000;
  localparam logic signed [31:0] LON_SPAN  = 32'sd360000000;
  localparam logic [7:0]  MM_PER_UDEG = 8'd111;
  // floor(x / 1e6) = (x * DEG_RECIP) >> DEG_SHIFT for x < 2^27
  localparam logic [27:0] DEG_RECIP = 28'd140737489;
  localparam int          DEG_SHIFT = 47;

  // shared divider size
  localparam int DIV_N = 52;
  localparam int DIV_D = 64;
  localparam logic [DIV_N-1:0] MS_PER_S  = 52'd1000;
  localparam logic [DIV_N-1:0] MS_PER_KS = 52'd1000000;

  localparam logic [15:0] COS_Q15 [0:COS_ENTRIES-1] = '{
    16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
    16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
    16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
    16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
    16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
    16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
    16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
    16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
    16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
    16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
    16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
    16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
    16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
  };

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] latitude_micro;
    logic signed [31:0] longitude_micro;
    logic signed [15:0] fix_accuracy;
    logic [31:0]        fix_time_ms;
  } gpt_in_t;

  typedef struct packed {
    logic [1:0]  fix_result;
    logic        command_ok;
    logic [1:0]  run_state;
    logic [31:0] elapsed_out;
    logic [63:0] total_distance_out;
    logic        recent_pace_valid;
    logic [31:0] recent_pace;
    logic        overall_pace_valid;
    logic [31:0] overall_pace;
  } gpt_out_t;

endpackage

// ===== sv/gpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gpt_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);
  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/gpt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpt_div #(
  parameter int N = 52,
  parameter int D = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quot_o
);
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  q_q;
  logic [D-1:0]  r_q;
  logic [D-1:0]  dv_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [D:0]    shifted;
  logic          ge;

  always_comb begin
    shifted = {r_q, q_q[N-1]};
    ge      = shifted >= {1'b0, dv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= '0;
      dv_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        q_q    <= dividend_i;
        r_q    <= '0;
        dv_q   <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        r_q   <= ge ? D'(shifted - {1'b0, dv_q}) : shifted[D-1:0];
        q_q   <= {q_q[N-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

// ===== sv/gps_pace_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pace_tracker
// Running-pace tracker: GPS fixes, run commands and second ticks in, one
// result item per event out. Sample ring kept in a RAM.
// ----------------------------------------------------------------------------
// Flow: a command runs the ring walk and the paces; a fix that forms a leg first
// passes the leg datapath (multiplies, 32-step root). One item at a time; the
// next item is taken once the result is in the output register. The shared
// 52-step divider and the ring walk (a read and an accumulate state per sample)
// set the gap between items.
// Reset: asynchronous, all control state cleared, ring marked empty at once.
module gps_pace_tracker
  import gpt_pkg::*;
#(
  parameter int RING_DEPTH = gpt_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gpt_pkg::gpt_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gpt_pkg::gpt_out_t             out_item_o,
  input  logic                          cfg_we_i,
  input  logic [gpt_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [gpt_pkg::CFG_DW-1:0]    cfg_data_i
);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int TW = 20 + PW;
  localparam int SW = 24 + PW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_EXEC   = 5'd1;
  localparam logic [4:0] S_LEG1   = 5'd2;
  localparam logic [4:0] S_LEG2   = 5'd3;
  localparam logic [4:0] S_LEG3   = 5'd4;
  localparam logic [4:0] S_SQA    = 5'd5;
  localparam logic [4:0] S_SQB    = 5'd6;
  localparam logic [4:0] S_SUM    = 5'd7;
  localparam logic [4:0] S_SQRT   = 5'd8;
  localparam logic [4:0] S_ROUND  = 5'd9;
  localparam logic [4:0] S_CHECK  = 5'd10;
  localparam logic [4:0] S_WINIT  = 5'd11;
  localparam logic [4:0] S_WRD    = 5'd12;
  localparam logic [4:0] S_WACC   = 5'd13;
  localparam logic [4:0] S_RFIN   = 5'd14;
  localparam logic [4:0] S_RDIV   = 5'd15;
  localparam logic [4:0] S_OVR    = 5'd16;
  localparam logic [4:0] S_ODIV   = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;

  logic [4:0] state_q;

  // configuration
  logic [19:0] min_step_q, max_int_q;
  logic [7:0]  max_spd_q;
  logic [23:0] window_q;
  logic [15:0] stale_q;

  // run state
  gpt_in_t            item_q;
  logic [1:0]         mode_q;
  logic signed [27:0] base_lat_q;
  logic signed [28:0] base_lon_q;
  logic [31:0]        base_time_q;
  logic               base_valid_q;
  logic [31:0]        elapsed_q, idle_q;
  logic [63:0]        dist_sum_q;
  logic [RING_DEPTH-1:0] svalid_q;
  logic [PW-1:0]      ptr_q;
  logic [1:0]         fix_q;
  logic               ok_q;

  // leg datapath
  logic [27:0] alat_q, alon_q;
  logic [6:0]  deg_q;
  logic [31:0] delta_q;
  logic [39:0] lim_q;
  logic [35:0] a_q;
  logic [34:0] c_q;
  logic [15:0] cos_q;
  logic [50:0] bp_q;
  logic [36:0] b_q;
  logic [63:0] a2_q, b2_q;
  logic [63:0] sq_v_q, sq_r_q, sq_bit_q;
  logic [31:0] dist_q;

  // ring walk and paces
  logic [PW-1:0] widx_q, wcnt_q;
  logic [TW-1:0] tsum_q;
  logic [SW-1:0] dsum_q;
  logic          rv_q, ov_q;
  logic [31:0]   rp_q, opace_q;

  gpt_out_t out_q;
  logic     out_valid_q;

  // combinational helpers
  logic               fix_ok;
  logic signed [31:0] dlat, dlon, dlon_w;
  logic [27:0]        base_abs;
  logic [54:0]        deg_prod;
  logic [7:0]         deg_raw;
  logic [31:0]        sq_in;
  logic [63:0]        sq_out;
  logic [64:0]        sq_sum;
  logic [63:0]        sq_try;
  logic               rebase_c, reject_c, commit_c;
  logic [64:0]        dsum_add;
  logic [TW-1:0]      tsum_d;
  logic [SW-1:0]      dsum_d;
  logic [43:0]        ram_wdata, ram_rdata;
  logic               div_start, div_done;
  logic [DIV_N-1:0]   div_dividend, div_quot;
  logic [DIV_D-1:0]   div_divisor;
  logic [31:0]        quot_sat;
  logic [PW-1:0]      ptr_next;

  always_comb begin
    fix_ok = (item_q.latitude_micro >= -LAT_LIMIT) && (item_q.latitude_micro <= LAT_LIMIT)
          && (item_q.longitude_micro >= -LON_LIMIT)
          && (item_q.longitude_micro <= LON_LIMIT)
          && (item_q.fix_accuracy >= 16'sd0) && (item_q.fix_accuracy <= 16'sd200);
    dlat = item_q.latitude_micro - 32'(base_lat_q);
    dlon = item_q.longitude_micro - 32'(base_lon_q);
    if (dlon > LON_LIMIT) begin
      dlon_w = dlon - LON_SPAN;
    end else if (dlon < -LON_LIMIT) begin
      dlon_w = dlon + LON_SPAN;
    end else begin
      dlon_w = dlon;
    end
    base_abs = base_lat_q[27] ? 28'(-base_lat_q) : 28'(base_lat_q);
    deg_prod = {27'b0, base_abs} * {27'b0, DEG_RECIP};
    deg_raw  = deg_prod[DEG_SHIFT+7:DEG_SHIFT];
  end

  // one squarer shared by both leg components
  assign sq_in  = (state_q == S_SQA) ? a_q[31:0] : b_q[31:0];
  assign sq_out = {32'b0, sq_in} * {32'b0, sq_in};
  assign sq_sum = {1'b0, a2_q} + {1'b0, b2_q};
  assign sq_try = sq_r_q + sq_bit_q;

  always_comb begin
    rebase_c = (delta_q == 32'd0) || (delta_q > {12'b0, max_int_q})
            || ({8'b0, dist_q} > lim_q);
    reject_c = !rebase_c && (dist_q <= {12'b0, min_step_q});
    commit_c = (state_q == S_CHECK) && !rebase_c && !reject_c;
    dsum_add = {1'b0, dist_sum_q} + {33'b0, dist_q};
    ptr_next = (ptr_q == PW'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
    ram_wdata = {delta_q[19:0], (dist_q > 32'hFF_FFFF) ? 24'hFF_FFFF : dist_q[23:0]};
    tsum_d = tsum_q + TW'(ram_rdata[43:24]);
    dsum_d = dsum_q + SW'(ram_rdata[23:0]);
  end

  gpt_ram #(.W(44), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (commit_c),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (widx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    div_start = ((state_q == S_RFIN) && (dsum_q != '0))
             || ((state_q == S_OVR) && (dist_sum_q != 64'd0));
    if (state_q == S_RFIN) begin
      div_dividend = DIV_N'(tsum_q) * MS_PER_S;
      div_divisor  = DIV_D'(dsum_q);
    end else begin
      div_dividend = {20'b0, elapsed_q} * MS_PER_KS;
      div_divisor  = dist_sum_q;
    end
    quot_sat = (div_quot[DIV_N-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
  end

  gpt_div #(.N(DIV_N), .D(DIV_D)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_step_q   <= RST_MIN_STEP;
      max_int_q    <= RST_MAX_INT;
      max_spd_q    <= RST_MAX_SPD;
      window_q     <= RST_WINDOW;
      stale_q      <= RST_STALE;
      item_q       <= '0;
      mode_q       <= MODE_WAIT;
      base_lat_q   <= '0;
      base_lon_q   <= '0;
      base_time_q  <= '0;
      base_valid_q <= 1'b0;
      elapsed_q    <= '0;
      idle_q       <= 32'(RST_STALE) + 32'd1;
      dist_sum_q   <= '0;
      svalid_q     <= '0;
      ptr_q        <= '0;
      fix_q        <= FIX_NONE;
      ok_q         <= 1'b1;
      alat_q       <= '0;
      alon_q       <= '0;
      deg_q        <= '0;
      delta_q      <= '0;
      lim_q        <= '0;
      a_q          <= '0;
      c_q          <= '0;
      cos_q        <= '0;
      bp_q         <= '0;
      b_q          <= '0;
      a2_q         <= '0;
      b2_q         <= '0;
      sq_v_q       <= '0;
      sq_r_q       <= '0;
      sq_bit_q     <= '0;
      dist_q       <= '0;
      widx_q       <= '0;
      wcnt_q       <= '0;
      tsum_q       <= '0;
      dsum_q       <= '0;
      rv_q         <= 1'b0;
      ov_q         <= 1'b0;
      rp_q         <= '0;
      opace_q      <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_STEP: min_step_q <= cfg_data_i[19:0];
          CFG_MAX_INT:  max_int_q  <= cfg_data_i[19:0];
          CFG_MAX_SPD:  max_spd_q  <= cfg_data_i[7:0];
          CFG_WINDOW:   window_q   <= cfg_data_i;
          CFG_STALE:    stale_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // S_OUT reloads the register itself
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          if ((item_q.op == OP_FIX) && fix_ok && (mode_q == MODE_RUN) && base_valid_q) begin
            state_q <= S_LEG1;
          end else begin
            state_q <= S_WINIT;
          end
          // a leg settles its result in S_CHECK
          if (item_q.op != OP_FIX) begin
            fix_q <= FIX_NONE;
          end else if (!fix_ok) begin
            fix_q <= FIX_REJECT;
          end else begin
            fix_q <= FIX_BASE;
          end
          ok_q <= !(((item_q.op == OP_START) && (mode_q != MODE_READY))
                 || ((item_q.op == OP_RESUME) && (mode_q != MODE_PAUSE)));
          case (item_q.op)
            OP_FIX: begin
              if (fix_ok) begin
                if (mode_q != MODE_RUN || !base_valid_q) begin
                  if (mode_q == MODE_WAIT) begin
                    mode_q <= MODE_READY;
                  end
                  base_lat_q   <= item_q.latitude_micro[27:0];
                  base_lon_q   <= item_q.longitude_micro[28:0];
                  base_time_q  <= item_q.fix_time_ms;
                  base_valid_q <= 1'b1;
                end else begin
                  alat_q  <= dlat[31] ? 28'(-dlat) : dlat[27:0];
                  alon_q  <= dlon_w[31] ? 28'(-dlon_w) : dlon_w[27:0];
                  deg_q   <= (deg_raw > 8'd90) ? 7'd90 : deg_raw[6:0];
                  delta_q <= item_q.fix_time_ms - base_time_q;
                end
              end
            end
            OP_START: begin
              if (mode_q == MODE_READY) begin
                mode_q       <= MODE_RUN;
                elapsed_q    <= '0;
                dist_sum_q   <= '0;
                base_valid_q <= 1'b0;
                svalid_q     <= '0;
                ptr_q        <= '0;
                idle_q       <= 32'(stale_q) + 32'd1;
              end
            end
            OP_PAUSE: begin
              if (mode_q == MODE_RUN) begin
                mode_q       <= MODE_PAUSE;
                base_valid_q <= 1'b0;
              end
            end
            OP_RESUME: begin
              if (mode_q == MODE_PAUSE) begin
                mode_q       <= MODE_RUN;
                base_valid_q <= 1'b0;
                idle_q       <= 32'(stale_q) + 32'd1;
              end
            end
            OP_TICK: begin
              if (mode_q == MODE_RUN) begin
                if (elapsed_q != 32'hFFFF_FFFF) elapsed_q <= elapsed_q + 32'd1;
                if (idle_q != 32'hFFFF_FFFF) idle_q <= idle_q + 32'd1;
              end
            end
            default: ;
          endcase
        end

        S_LEG1: begin
          a_q     <= {8'b0, alat_q} * {28'b0, MM_PER_UDEG};
          c_q     <= {7'b0, alon_q} * {27'b0, MM_PER_UDEG};
          cos_q   <= COS_Q15[deg_q];
          lim_q   <= {8'b0, delta_q} * {32'b0, max_spd_q};
          state_q <= S_LEG2;
        end

        S_LEG2: begin
          bp_q    <= {16'b0, c_q} * {35'b0, cos_q};
          state_q <= S_LEG3;
        end

        S_LEG3: begin
          // Q15 product, rounded half up
          b_q     <= 37'(({1'b0, bp_q} + 52'd16384) >> 15);
          state_q <= S_SQA;
        end

        S_SQA: begin
          if (a_q[35:32] != '0 || b_q[36:32] != '0) begin
            dist_q  <= 32'hFFFF_FFFF;
            state_q <= S_CHECK;
          end else begin
            a2_q    <= sq_out;
            state_q <= S_SQB;
          end
        end

        S_SQB: begin
          b2_q    <= sq_out;
          state_q <= S_SUM;
        end

        S_SUM: begin
          if (sq_sum[64]) begin
            dist_q  <= 32'hFFFF_FFFF;
            state_q <= S_CHECK;
          end else begin
            sq_v_q   <= sq_sum[63:0];
            sq_r_q   <= '0;
            sq_bit_q <= 64'h4000_0000_0000_0000;
            state_q  <= S_SQRT;
          end
        end

        S_SQRT: begin
          if (sq_v_q >= sq_try) begin
            sq_v_q <= sq_v_q - sq_try;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            state_q <= S_ROUND;
          end
        end

        S_ROUND: begin
          // remainder above root: round up
          if (sq_v_q > sq_r_q) begin
            dist_q <= (sq_r_q[31:0] == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                       : sq_r_q[31:0] + 32'd1;
          end else begin
            dist_q <= sq_r_q[31:0];
          end
          state_q <= S_CHECK;
        end

        S_CHECK: begin
          if (rebase_c || commit_c) begin
            base_lat_q   <= item_q.latitude_micro[27:0];
            base_lon_q   <= item_q.longitude_micro[28:0];
            base_time_q  <= item_q.fix_time_ms;
            base_valid_q <= 1'b1;
          end
          if (rebase_c) begin
            fix_q <= FIX_BASE;
          end else if (reject_c) begin
            fix_q <= FIX_REJECT;
          end else begin
            fix_q            <= FIX_COMMIT;
            dist_sum_q       <= dsum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum_add[63:0];
            svalid_q[ptr_q]  <= 1'b1;
            ptr_q            <= ptr_next;
            idle_q           <= '0;
          end
          state_q <= S_WINIT;
        end

        S_WINIT: begin
          rv_q <= 1'b0;
          rp_q <= '0;
          if (idle_q <= {16'b0, stale_q}) begin
            widx_q  <= (ptr_q == '0) ? PW'(RING_DEPTH - 1) : ptr_q - 1'b1;
            wcnt_q  <= '0;
            tsum_q  <= '0;
            dsum_q  <= '0;
            state_q <= S_WRD;
          end else begin
            state_q <= S_OVR;
          end
        end

        S_WRD: begin
          // RAM read of widx_q is under way; data shows next cycle
          state_q <= svalid_q[widx_q] ? S_WACC : S_RFIN;
        end

        S_WACC: begin
          tsum_q <= tsum_d;
          dsum_q <= dsum_d;
          if (dsum_d >= SW'(window_q) || wcnt_q == PW'(RING_DEPTH - 1)) begin
            state_q <= S_RFIN;
          end else begin
            widx_q  <= (widx_q == '0) ? PW'(RING_DEPTH - 1) : widx_q - 1'b1;
            wcnt_q  <= wcnt_q + 1'b1;
            state_q <= S_WRD;
          end
        end

        S_RFIN: begin
          state_q <= (dsum_q != '0) ? S_RDIV : S_OVR;
        end

        S_RDIV: begin
          if (div_done) begin
            rv_q    <= 1'b1;
            rp_q    <= quot_sat;
            state_q <= S_OVR;
          end
        end

        S_OVR: begin
          ov_q    <= 1'b0;
          opace_q <= '0;
          state_q <= (dist_sum_q != 64'd0) ? S_ODIV : S_OUT;
        end

        S_ODIV: begin
          if (div_done) begin
            ov_q    <= 1'b1;
            opace_q <= quot_sat;
            state_q <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.fix_result         <= fix_q;
            out_q.command_ok         <= ok_q;
            out_q.run_state          <= mode_q;
            out_q.elapsed_out        <= elapsed_q;
            out_q.total_distance_out <= dist_sum_q;
            out_q.recent_pace_valid  <= rv_q;
            out_q.recent_pace        <= rp_q;
            out_q.overall_pace_valid <= ov_q;
            out_q.overall_pace       <= opace_q;
            out_valid_q              <= 1'b1;
            state_q                  <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

// ===== sv/gpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_checker
// Port-level checks for the pace tracker, bound to the top level.
// ----------------------------------------------------------------------------
module gpt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input gpt_pkg::gpt_out_t          out_item_o
);
  import gpt_pkg::*;

  // one item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_recent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.recent_pace_valid |-> out_item_o.recent_pace == 32'd0)
    else $error("recent pace nonzero while invalid");

  a_overall_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.overall_pace_valid |-> out_item_o.overall_pace == 32'd0)
    else $error("overall pace nonzero while invalid");

  a_overall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_item_o.overall_pace_valid == (out_item_o.total_distance_out != 64'd0))
    else $error("overall pace valid does not follow distance");

endmodule

bind gps_pace_tracker gpt_checker u_gpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/gps_pace_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pace_tracker_tb
// Self-checking bench for the pace tracker. A cycle-free model predicts every
// result item from the accepted input items. Stimulus is a directed opening,
// then random runs of fixes, ticks and commands under several register
// settings, with random input gaps, random output stalls and one long output hold.
// ----------------------------------------------------------------------------
module gps_pace_tracker_tb;
  import gpt_pkg::*;

  class pace_scoreboard;
    logic [19:0] min_step, max_int;
    logic [7:0]  max_spd;
    logic [23:0] window;
    logic [15:0] stale;
    logic [1:0]  mode;
    longint      base_lat, base_lon;
    logic [31:0] base_t;
    bit          base_ok;
    logic [31:0] elapsed, idle_s;
    logic [63:0] dist_sum;
    logic [19:0] leg_time [16];
    logic [23:0] leg_dist [16];
    bit          leg_ok [16];
    int          ptr;
    gpt_out_t    result_q[$];
    int          errors, n_checked, n_commit, n_base;

    function new();
      min_step = RST_MIN_STEP; max_int = RST_MAX_INT; max_spd = RST_MAX_SPD;
      window = RST_WINDOW; stale = RST_STALE;
      mode = MODE_WAIT; base_lat = 0; base_lon = 0; base_t = 0; base_ok = 0;
      elapsed = 0; dist_sum = 0;
      errors = 0; n_checked = 0; n_commit = 0; n_base = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      for (int i = 0; i < 16; i++) begin
        leg_ok[i] = 0;
      end
      ptr = 0;
      idle_s = {16'd0, stale} + 32'd1;
    endfunction

    function void set_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_MIN_STEP: min_step = val[19:0];
        CFG_MAX_INT:  max_int = val[19:0];
        CFG_MAX_SPD:  max_spd = val[7:0];
        CFG_WINDOW:   window = val;
        CFG_STALE:    stale = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function logic [63:0] root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [31:0] leg_len(longint lat, longint lon);
      longint dlat, dlon, blat;
      logic [63:0] alat, alon, deg, a, b, r;
      logic [64:0] s;
      dlat = lat - base_lat;
      dlon = lon - base_lon;
      if (dlon > 180000000) dlon = dlon - 360000000;
      else if (dlon < -180000000) dlon = dlon + 360000000;
      alat = dlat < 0 ? -dlat : dlat;
      alon = dlon < 0 ? -dlon : dlon;
      blat = base_lat < 0 ? -base_lat : base_lat;
      deg = blat / 1000000;
      if (deg > 90) deg = 90;
      a = alat * 64'd111;
      b = (alon * 64'd111 * COS_Q15[deg] + 64'd16384) >> 15;
      if (a > 64'hFFFF_FFFF || b > 64'hFFFF_FFFF) return '1;
      s = {1'b0, a * a} + {1'b0, b * b};
      if (s[64]) return '1;
      r = root(s[63:0]);
      if (s[63:0] - r * r > r) r = r + 1;
      return r > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function void rebase(longint lat, longint lon, logic [31:0] t);
      base_lat = lat; base_lon = lon; base_t = t; base_ok = 1;
      n_base++;
    endfunction

    function logic [1:0] take_fix(gpt_in_t it);
      longint lat, lon, acc;
      logic [31:0] delta, leg_d;
      logic [63:0] nsum;
      lat = longint'($signed(it.latitude_micro));
      lon = longint'($signed(it.longitude_micro));
      acc = longint'($signed(it.fix_accuracy));
      if (lat < -90000000 || lat > 90000000 || lon < -180000000 || lon > 180000000 ||
          acc < 0 || acc > 200) return FIX_REJECT;
      if (mode == MODE_WAIT) begin
        mode = MODE_READY;
        rebase(lat, lon, it.fix_time_ms);
        return FIX_BASE;
      end
      if (mode != MODE_RUN || !base_ok) begin
        rebase(lat, lon, it.fix_time_ms);
        return FIX_BASE;
      end
      delta = it.fix_time_ms - base_t;
      leg_d = leg_len(lat, lon);
      if (delta == 0 || delta > {12'd0, max_int} ||
          64'(leg_d) > 64'(delta) * 64'(max_spd)) begin
        rebase(lat, lon, it.fix_time_ms);
        return FIX_BASE;
      end
      if (leg_d <= {12'd0, min_step}) return FIX_REJECT;
      nsum = dist_sum + 64'(leg_d);
      dist_sum = nsum < dist_sum ? '1 : nsum;
      leg_time[ptr] = delta[19:0];
      leg_dist[ptr] = leg_d > 32'hFF_FFFF ? 24'hFF_FFFF : leg_d[23:0];
      leg_ok[ptr] = 1;
      ptr = (ptr + 1) % 16;
      idle_s = 0;
      rebase(lat, lon, it.fix_time_ms);
      n_commit++;
      return FIX_COMMIT;
    endfunction

    // predict the result of one accepted item
    function void note_item(gpt_in_t it);
      gpt_out_t w;
      logic [63:0] tsum, dsum, p;
      int idx;
      w = '0;
      w.fix_result = FIX_NONE;
      w.command_ok = 1;
      case (it.op)
        OP_FIX: w.fix_result = take_fix(it);
        OP_START: begin
          if (mode == MODE_READY) begin
            mode = MODE_RUN; elapsed = 0; dist_sum = 0; base_ok = 0;
            clear_ring();
          end else w.command_ok = 0;
        end
        OP_PAUSE: if (mode == MODE_RUN) begin
          mode = MODE_PAUSE; base_ok = 0;
        end
        OP_RESUME: begin
          if (mode == MODE_PAUSE) begin
            mode = MODE_RUN; base_ok = 0; idle_s = {16'd0, stale} + 32'd1;
          end else w.command_ok = 0;
        end
        OP_TICK: if (mode == MODE_RUN) begin
          if (elapsed != '1) elapsed++;
          if (idle_s != '1) idle_s++;
        end
        default: ;
      endcase
      tsum = 0; dsum = 0;
      if (idle_s <= {16'd0, stale}) begin
        for (int k = 0; k < 16; k++) begin
          idx = (ptr + 15 - k) % 16;
          if (!leg_ok[idx]) break;
          tsum += leg_time[idx];
          dsum += leg_dist[idx];
          if (dsum >= window) break;
        end
        if (dsum != 0) begin
          p = tsum * 1000 / dsum;
          w.recent_pace_valid = 1;
          w.recent_pace = p > 64'hFFFF_FFFF ? '1 : p[31:0];
        end
      end
      if (dist_sum != 0) begin
        p = 64'(elapsed) * 64'd1000000 / dist_sum;
        w.overall_pace_valid = 1;
        w.overall_pace = p > 64'hFFFF_FFFF ? '1 : p[31:0];
      end
      w.run_state = mode;
      w.elapsed_out = elapsed;
      w.total_distance_out = dist_sum;
      result_q.push_back(w);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(gpt_out_t got);
      gpt_out_t w;
      if (result_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      w = result_q.pop_front();
      n_checked++;
      cmp("fix_result", w.fix_result, got.fix_result);
      cmp("command_ok", w.command_ok, got.command_ok);
      cmp("run_state", w.run_state, got.run_state);
      cmp("elapsed_out", w.elapsed_out, got.elapsed_out);
      cmp("total_distance_out", w.total_distance_out, got.total_distance_out);
      cmp("recent_pace_valid", w.recent_pace_valid, got.recent_pace_valid);
      cmp("recent_pace", w.recent_pace, got.recent_pace);
      cmp("overall_pace_valid", w.overall_pace_valid, got.overall_pace_valid);
      cmp("overall_pace", w.overall_pace, got.overall_pace);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  gpt_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  gpt_out_t out_item;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  pace_scoreboard sb = new();
  bit quiet = 0;
  bit press_go = 0;
  bit press_hold = 0;
  int stall_left = 0;
  int dead_cycles = 0;

  longint cur_lat, cur_lon;
  logic [31:0] cur_t;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  gps_pace_tracker i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_item(in_item);
    if (out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= 5000) begin
      $display("watchdog: no progress for %0d cycles", dead_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold
  always @(posedge clk) begin
    if (press_hold) begin
      out_stall <= 1;
    end else if (quiet) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    wait (press_go);
    press_hold <= 1;
    repeat (400) @(posedge clk);
    press_hold <= 0;
  end

  task automatic send(gpt_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic gpt_in_t mk_fix(longint lat, longint lon, int acc, logic [31:0] t);
    gpt_in_t it;
    it.op = OP_FIX;
    it.latitude_micro = lat[31:0];
    it.longitude_micro = lon[31:0];
    it.fix_accuracy = acc[15:0];
    it.fix_time_ms = t;
    return it;
  endfunction

  function automatic gpt_in_t mk_op(logic [2:0] op);
    gpt_in_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // leaves the write enable high; set_all drops it after the last write
  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_cfg(idx, val);
  endtask

  task automatic set_all(int ms, int mi, int sp, int wn, int st);
    write_cfg(CFG_MIN_STEP, CFG_DW'(ms));
    write_cfg(CFG_MAX_INT, CFG_DW'(mi));
    write_cfg(CFG_MAX_SPD, CFG_DW'(sp));
    write_cfg(CFG_WINDOW, CFG_DW'(wn));
    write_cfg(CFG_STALE, CFG_DW'(st));
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic longint jitter(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly a plausible run: moving fixes, ticks, pause and resume; some noise
  task automatic random_run(int n, int big_legs);
    gpt_in_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if (big_legs && $urandom_range(0, 9) == 0) begin
          cur_lat += jitter(200000);
          cur_t += $urandom_range(80000, 200000);
        end else begin
          cur_lat += jitter(700);
          cur_lon += jitter(700);
          case ($urandom_range(0, 19))
            0: cur_t += 0;
            1: cur_t += $urandom_range(100000, 700000);
            default: cur_t += $urandom_range(200, 6000);
          endcase
        end
        if (cur_lat > 89000000 || cur_lat < -89000000) cur_lat = jitter(1000000);
        if (cur_lon > 180000000) cur_lon -= 360000000;
        if (cur_lon < -180000000) cur_lon += 360000000;
        it = mk_fix(cur_lat, cur_lon, $urandom_range(0, 200), cur_t);
      end else if (r < 75) begin
        it = mk_op(OP_TICK);
      end else if (r < 80) begin
        it = mk_op(OP_PAUSE);
      end else if (r < 88) begin
        it = mk_op(OP_RESUME);
      end else if (r < 90) begin
        it = mk_op(OP_START);
      end else begin
        it.op = 3'($urandom_range(0, 7));
        it.latitude_micro = $urandom;
        it.longitude_micro = $urandom;
        it.fix_accuracy = 16'($urandom);
        it.fix_time_ms = $urandom;
        if (r < 94) it.op = OP_FIX;
      end
      send(it);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // commands outside their mode, unused ops, invalid fixes, fixes at the limits
    send(mk_op(OP_START));
    send(mk_op(OP_RESUME));
    send(mk_op(OP_PAUSE));
    send(mk_op(OP_TICK));
    send(mk_op(3'd5));
    send(mk_op(3'd6));
    send(mk_op(3'd7));
    send(mk_fix(90000001, 0, 10, 0));
    send(mk_fix(0, -180000001, 10, 0));
    send(mk_fix(0, 0, -1, 0));
    send(mk_fix(0, 0, 201, 0));
    send(mk_fix(90000000, 180000000, 200, 32'hFFFF_FFFF));
    send(mk_fix(-90000000, -180000000, 0, 0));
    send(mk_op(OP_START));
    send(mk_op(OP_RESUME));
    // leg across the date line, timestamp wrapping
    send(mk_fix(0, 179999850, 5, 32'hFFFF_F000));
    send(mk_fix(0, -179999850, 5, 32'h0000_0000 + 32'd904));
    send(mk_op(OP_TICK));
    send(mk_op(OP_TICK));
    send(mk_op(OP_PAUSE));
    send(mk_op(OP_TICK));
    send(mk_op(OP_RESUME));
    send(mk_fix(1000000, 0, 0, 10000));
    send(mk_fix(1000300, 200, 0, 13000));
    send(mk_fix(1000300, 200, 0, 13000));

    cur_lat = 45000000; cur_lon = 7000000; cur_t = 20000;
    press_go = 1;
    random_run(200, 0);
    drain();

    set_all(0, 600000, 255, 1, 0);
    // leg longer than a ring entry holds
    send(mk_fix(0, 0, 0, 0));
    send(mk_fix(200000, 0, 0, 100000));
    send(mk_op(OP_TICK));
    cur_lat = 200000; cur_lon = 0; cur_t = 100000;
    random_run(150, 1);
    drain();

    set_all(1000000, 1, 1, 10000000, 65535);
    cur_lat = -60000000; cur_t = 0;
    random_run(100, 0);
    drain();

    set_all(5000, 60000, 40, 50000, 30);
    cur_lat = 80000000; cur_lon = -179000000;
    random_run(170, 1);
    quiet = 1;
    random_run(80, 0);
    drain();

    $display("checked %0d result items: %0d committed legs, %0d baselines",
             sb.n_checked, sb.n_commit, sb.n_base);
    $display("covered 4 register settings, command misuse, invalid and noisy fixes");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gpt_pkg.sv
sv/gpt_ram.sv
sv/gpt_div.sv
sv/gps_pace_tracker.sv
sv/gpt_checker.sv
tb/gps_pace_tracker_tb.sv
